// ===== rtl/core/mpoc_pkg.sv =====
// mpoc_pkg: shared types and codes of the multi-pattern occurrence counter
// item layouts, mode and status codes, controller states, datapath commands
// no dependencies
package mpoc_pkg;

   localparam logic [2:0] MODE_PATTERN = 3'd0;
   localparam logic [2:0] MODE_BUILD   = 3'd1;
   localparam logic [2:0] MODE_TEXT    = 3'd2;
   localparam logic [2:0] MODE_READ    = 3'd3;
   localparam logic [2:0] MODE_CLEAR   = 3'd4;

   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_NODE_FULL    = 2'd1;
   localparam logic [1:0] ST_PATTERN_FULL = 2'd2;
   localparam logic [1:0] ST_BAD_INDEX    = 2'd3;

   typedef struct packed {
      logic [2:0] mode;
      logic [4:0] symbol;
      logic       last;
      logic [9:0] pattern_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] hit_count;
      logic [9:0]  assigned_id;
      logic [11:0] match_node;
   } rsp_type;

   typedef enum logic [4:0] {
      S_SWEEP, S_IDLE, S_PAT_RD, S_PAT_WR, S_TXT_RD, S_TXT_CK, S_SUF_RD, S_SUF_CK,
      S_RD_PEND, S_RD_HIT, S_RD_OUT, S_BR_RD, S_BR_CK, S_BQ_POP, S_BQ_U, S_BQ_FU,
      S_BC_RD, S_BC_CK, S_BF_RD, S_BF_CK, S_BT_F, S_BT_O, S_DONE
   } ctl_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_ACCEPT, OP_SWEEP, OP_PAT_RD, OP_PAT_WR, OP_TXT_RD, OP_TXT_CK,
      OP_SUF_RD, OP_SUF_CK, OP_RD_PEND, OP_RD_HIT, OP_RD_OUT, OP_BR_RD, OP_BR_CK,
      OP_BQ_POP, OP_BQ_U, OP_BQ_FU, OP_BC_RD, OP_BC_CK, OP_BF_RD, OP_BF_CK,
      OP_BT_F, OP_BT_O
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      emit;
   } dp_cmd_type;

   typedef struct packed {
      logic sym_bad;
      logic idx_bad;
      logic g_zero;
      logic u_zero;
      logic f_zero;
      logic tag_set;
      logic sym_last;
      logic q_empty;
      logic sweep_last;
   } dp_flags_type;

endpackage

// ===== rtl/core/multi_pattern_occurrence_counter.sv =====
// multi_pattern_occurrence_counter: top level, aho-corasick occurrence counter
// depends on mpoc_pkg, mpoc_ctrl, mpoc_dp (and mpoc_ram below it)
//
// An item is taken when start is high and busy is low; its one result shows on
// rsp_item for a single cycle marked by rsp_valid, which cannot be held off, so
// sample it when it comes. Items are handled one at a time by a sequencer over
// table memories with one write port and one registered read port. A text char
// follows failure links until an edge is found, then walks the suffix chain and
// counts each tagged node on it; a build scans the root's children, then per
// queued node scans every letter and follows failure links for each child.
// Clear sweeps the trie memory one entry a cycle; the same sweep runs after
// reset with busy high and no result.
module multi_pattern_occurrence_counter import mpoc_pkg::*; #(
   parameter int MAX_NODES    = 4096,
   parameter int MAX_PATTERNS = 1024,
   parameter int ALPHABET     = 26,
   parameter int COUNT_BITS   = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   dp_cmd_type   cmd;
   dp_flags_type flags;

   mpoc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_item.mode),
      .flags    (flags),
      .busy     (busy),
      .cmd      (cmd)
   );

   mpoc_dp #(
      .MAX_NODES    (MAX_NODES),
      .MAX_PATTERNS (MAX_PATTERNS),
      .ALPHABET     (ALPHABET),
      .COUNT_BITS   (COUNT_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .flags     (flags),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   a_single_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not start work");

   a_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while work is still running");

endmodule

// ===== rtl/core/mpoc_ram.sv =====
// mpoc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module mpoc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/mpoc_ctrl.sv =====
// mpoc_ctrl: sequencer of the occurrence counter, one operation per state
// depends on mpoc_pkg; drives mpoc_dp through command and flag structs
module mpoc_ctrl import mpoc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [2:0]   req_mode,
   input  dp_flags_type flags,
   output logic         busy,
   output dp_cmd_type   cmd
);

   ctl_state_type state_ff, state_in;
   logic          report_ff, report_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_SWEEP;
         report_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         report_ff <= report_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      report_in = report_ff;
      cmd.op    = OP_NONE;
      cmd.emit  = 1'b0;
      unique case (state_ff)
         S_SWEEP: begin
            cmd.op = OP_SWEEP;
            if (flags.sweep_last) begin
               state_in  = report_ff ? S_DONE : S_IDLE;
               report_in = 1'b0;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.op = OP_ACCEPT;
               priority if (req_mode == MODE_PATTERN && !flags.sym_bad) begin
                  state_in = S_PAT_RD;
               end else if (req_mode == MODE_TEXT && !flags.sym_bad) begin
                  state_in = S_TXT_RD;
               end else if (req_mode == MODE_BUILD) begin
                  state_in = S_BR_RD;
               end else if (req_mode == MODE_READ && !flags.idx_bad) begin
                  state_in = S_RD_PEND;
               end else if (req_mode == MODE_CLEAR) begin
                  state_in  = S_SWEEP;
                  report_in = 1'b1;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_PAT_RD: begin
            cmd.op   = OP_PAT_RD;
            state_in = S_PAT_WR;
         end
         S_PAT_WR: begin
            cmd.op   = OP_PAT_WR;
            state_in = S_DONE;
         end
         S_TXT_RD: begin
            cmd.op   = OP_TXT_RD;
            state_in = S_TXT_CK;
         end
         S_TXT_CK: begin
            cmd.op   = OP_TXT_CK;
            // no edge here: follow the failure link and retry
            state_in = (!flags.u_zero && flags.g_zero) ? S_TXT_RD : S_SUF_RD;
         end
         S_SUF_RD: begin
            cmd.op   = OP_SUF_RD;
            state_in = S_SUF_CK;
         end
         S_SUF_CK: begin
            cmd.op   = OP_SUF_CK;
            state_in = flags.tag_set ? S_SUF_RD : S_DONE;
         end
         S_RD_PEND: begin
            cmd.op   = OP_RD_PEND;
            state_in = S_RD_HIT;
         end
         S_RD_HIT: begin
            cmd.op   = OP_RD_HIT;
            state_in = S_RD_OUT;
         end
         S_RD_OUT: begin
            cmd.op   = OP_RD_OUT;
            state_in = S_DONE;
         end
         S_BR_RD: begin
            cmd.op   = OP_BR_RD;
            state_in = S_BR_CK;
         end
         S_BR_CK: begin
            cmd.op   = OP_BR_CK;
            state_in = flags.sym_last ? S_BQ_POP : S_BR_RD;
         end
         S_BQ_POP: begin
            cmd.op   = OP_BQ_POP;
            state_in = flags.q_empty ? S_DONE : S_BQ_U;
         end
         S_BQ_U: begin
            cmd.op   = OP_BQ_U;
            state_in = S_BQ_FU;
         end
         S_BQ_FU: begin
            cmd.op   = OP_BQ_FU;
            state_in = S_BC_RD;
         end
         S_BC_RD: begin
            cmd.op   = OP_BC_RD;
            state_in = S_BC_CK;
         end
         S_BC_CK: begin
            cmd.op = OP_BC_CK;
            if (flags.g_zero) begin
               state_in = flags.sym_last ? S_BQ_POP : S_BC_RD;
            end else begin
               state_in = S_BF_RD;
            end
         end
         S_BF_RD: begin
            cmd.op   = OP_BF_RD;
            state_in = S_BF_CK;
         end
         S_BF_CK: begin
            cmd.op   = OP_BF_CK;
            state_in = (!flags.f_zero && flags.g_zero) ? S_BF_RD : S_BT_F;
         end
         S_BT_F: begin
            cmd.op   = OP_BT_F;
            state_in = S_BT_O;
         end
         S_BT_O: begin
            cmd.op   = OP_BT_O;
            state_in = flags.sym_last ? S_BQ_POP : S_BC_RD;
         end
         S_DONE: begin
            cmd.emit = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== rtl/core/mpoc_dp.sv =====
// mpoc_dp: datapath of the occurrence counter: trie, link, tag, count, id and
// queue memories, walk registers and the result register
// depends on mpoc_pkg and mpoc_ram; commanded by mpoc_ctrl
module mpoc_dp import mpoc_pkg::*; #(
   parameter int MAX_NODES    = 4096,
   parameter int MAX_PATTERNS = 1024,
   parameter int ALPHABET     = 26,
   parameter int COUNT_BITS   = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  req_type      req_item,
   input  dp_cmd_type   cmd,
   output dp_flags_type flags,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);

   localparam int NW     = $clog2(MAX_NODES);
   localparam int NCW    = $clog2(MAX_NODES + 1);
   localparam int PAW    = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
   localparam int PCW    = $clog2(MAX_PATTERNS + 1);
   localparam int SYW    = $clog2(ALPHABET);
   localparam int GDEPTH = MAX_NODES * ALPHABET;
   localparam int GAW    = $clog2(GDEPTH);
   localparam logic [GAW-1:0] ALPHA_G    = GAW'(ALPHABET);
   localparam logic [GAW-1:0] SWEEP_LAST = GAW'(GDEPTH - 1);
   localparam logic [GAW-1:0] NODES_G    = GAW'(MAX_NODES);

   // control registers
   logic [NW-1:0]  cursor_ff, cursor_in;
   logic [NW-1:0]  text_ff, text_in;
   logic [NCW-1:0] nodes_used_ff, nodes_used_in;
   logic [PCW-1:0] pat_used_ff, pat_used_in;
   logic [GAW-1:0] sweep_ff, sweep_in;
   logic           rsp_valid_ff;
   // working and result registers
   req_type        req_ff, req_in;
   logic [NW-1:0]  u_ff, u_in, f_ff, f_in, o_ff, o_in, fu_ff, fu_in;
   logic           tf_ff, tf_in;
   logic [SYW-1:0] sym_i_ff, sym_i_in;
   logic [NCW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [1:0]     res_status_ff, res_status_in;
   logic [31:0]    res_hits_ff, res_hits_in;
   logic [9:0]     res_id_ff, res_id_in;
   logic [11:0]    res_node_ff, res_node_in;

   // memory ports
   logic                  g_we, fl_we, tg_we, ht_we, pe_we, qu_we;
   logic [GAW-1:0]        g_waddr, g_addr;
   logic [NW-1:0]         g_wdata, g_rd;
   logic [NW-1:0]         fl_waddr, fl_raddr, fl_wdata, fl_rd;
   logic [NW-1:0]         tg_waddr, tg_raddr;
   logic                  tg_wdata, tg_rd;
   logic [NW-1:0]         ht_waddr, ht_raddr;
   logic [COUNT_BITS-1:0] ht_wdata, ht_rd, ht_inc;
   logic [PAW-1:0]        pe_waddr, pe_raddr;
   logic [NW-1:0]         pe_wdata, pe_rd;
   logic [NW-1:0]         qu_wdata, qu_rd;

   logic [NW-1:0]            g_node;
   logic [GAW-1:0]           g_sym;
   logic                     nodes_full, pat_full, in_sweep_low;
   logic [NW-1:0]            nxt;
   logic                     pat_ok;
   logic [COUNT_BITS+31:0]   hits_wide;
   logic [31:0]              hits_sat;
   logic [SYW-1:0]           sym_i_next;

   mpoc_ram #(.WIDTH(NW), .DEPTH(GDEPTH)) u_goto (
      .clock(clock), .wr_en(g_we), .wr_addr(g_waddr), .wr_data(g_wdata),
      .rd_addr(g_addr), .rd_data(g_rd));
   mpoc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fail (
      .clock(clock), .wr_en(fl_we), .wr_addr(fl_waddr), .wr_data(fl_wdata),
      .rd_addr(fl_raddr), .rd_data(fl_rd));
   mpoc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_tag (
      .clock(clock), .wr_en(tg_we), .wr_addr(tg_waddr), .wr_data(tg_wdata),
      .rd_addr(tg_raddr), .rd_data(tg_rd));
   mpoc_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_NODES)) u_hits (
      .clock(clock), .wr_en(ht_we), .wr_addr(ht_waddr), .wr_data(ht_wdata),
      .rd_addr(ht_raddr), .rd_data(ht_rd));
   mpoc_ram #(.WIDTH(NW), .DEPTH(MAX_PATTERNS)) u_pend (
      .clock(clock), .wr_en(pe_we), .wr_addr(pe_waddr), .wr_data(pe_wdata),
      .rd_addr(pe_raddr), .rd_data(pe_rd));
   mpoc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
      .clock(clock), .wr_en(qu_we), .wr_addr(tail_ff[NW-1:0]), .wr_data(qu_wdata),
      .rd_addr(head_ff[NW-1:0]), .rd_data(qu_rd));

   // trie address: node times alphabet plus letter
   always_comb begin
      unique case (cmd.op)
         OP_PAT_RD, OP_PAT_WR: g_node = cursor_ff;
         OP_BF_RD:             g_node = f_ff;
         default:              g_node = u_ff;
      endcase
      if (cmd.op == OP_PAT_RD || cmd.op == OP_PAT_WR || cmd.op == OP_TXT_RD) begin
         g_sym = GAW'(req_ff.symbol);
      end else begin
         g_sym = GAW'(sym_i_ff);
      end
   end

   assign g_addr = (GAW'(g_node) * ALPHA_G) + g_sym;

   assign nodes_full   = (nodes_used_ff == NCW'(MAX_NODES));
   assign pat_full     = (pat_used_ff == PCW'(MAX_PATTERNS));
   assign in_sweep_low = (sweep_ff < NODES_G);
   assign nxt          = (g_rd == '0) ? nodes_used_ff[NW-1:0] : g_rd;
   assign pat_ok       = !((g_rd == '0) && nodes_full);
   assign ht_inc       = (ht_rd == '1) ? ht_rd : ht_rd + COUNT_BITS'(1);
   assign hits_wide    = {32'b0, ht_rd};
   assign hits_sat     = (|hits_wide[COUNT_BITS+31:32]) ? '1 : hits_wide[31:0];
   assign sym_i_next   = flags.sym_last ? '0 : sym_i_ff + SYW'(1);

   assign flags.sym_bad    = (9'(req_item.symbol) >= 9'(ALPHABET));
   assign flags.idx_bad    = (17'(req_item.pattern_index) >= 17'(pat_used_ff));
   assign flags.g_zero     = (g_rd == '0);
   assign flags.u_zero     = (u_ff == '0);
   assign flags.f_zero     = (f_ff == '0);
   assign flags.tag_set    = tg_rd;
   assign flags.sym_last   = (sym_i_ff == SYW'(ALPHABET - 1));
   assign flags.q_empty    = (head_ff == tail_ff);
   assign flags.sweep_last = (sweep_ff == SWEEP_LAST);

   always_comb begin
      cursor_in     = cursor_ff;
      text_in       = text_ff;
      nodes_used_in = nodes_used_ff;
      pat_used_in   = pat_used_ff;
      sweep_in      = sweep_ff;
      req_in        = req_ff;
      u_in          = u_ff;
      f_in          = f_ff;
      o_in          = o_ff;
      fu_in         = fu_ff;
      tf_in         = tf_ff;
      sym_i_in      = sym_i_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      res_status_in = res_status_ff;
      res_hits_in   = res_hits_ff;
      res_id_in     = res_id_ff;
      res_node_in   = res_node_ff;

      g_we = 1'b0;  g_waddr  = g_addr;            g_wdata  = nodes_used_ff[NW-1:0];
      fl_we = 1'b0; fl_waddr = o_ff;              fl_wdata = g_rd;
      fl_raddr = f_ff;
      tg_we = 1'b0; tg_waddr = o_ff;              tg_wdata = tg_rd | tf_ff;
      tg_raddr = f_ff;
      ht_we = 1'b0; ht_waddr = f_ff;              ht_wdata = ht_inc;
      ht_raddr = f_ff;
      pe_we = 1'b0; pe_waddr = pat_used_ff[PAW-1:0]; pe_wdata = nxt;
      pe_raddr = PAW'(req_ff.pattern_index);
      qu_we = 1'b0; qu_wdata = o_ff;

      unique case (cmd.op)
         OP_ACCEPT: begin
            req_in      = req_item;
            res_hits_in = '0;
            res_node_in = '0;
            res_id_in   = (req_item.mode == MODE_READ) ? req_item.pattern_index : '0;
            if ((req_item.mode == MODE_PATTERN || req_item.mode == MODE_TEXT)
                && flags.sym_bad) begin
               res_status_in = ST_BAD_INDEX;
            end else if (req_item.mode == MODE_READ && flags.idx_bad) begin
               res_status_in = ST_BAD_INDEX;
            end else begin
               res_status_in = ST_OK;
            end
            u_in     = (req_item.mode == MODE_TEXT) ? text_ff : '0;
            sym_i_in = '0;
            head_in  = '0;
            tail_in  = '0;
         end
         OP_SWEEP: begin
            g_we     = 1'b1;
            g_waddr  = sweep_ff;
            g_wdata  = '0;
            fl_we    = in_sweep_low;
            fl_waddr = sweep_ff[NW-1:0];
            fl_wdata = '0;
            tg_we    = in_sweep_low;
            tg_waddr = sweep_ff[NW-1:0];
            tg_wdata = 1'b0;
            ht_we    = in_sweep_low;
            ht_waddr = sweep_ff[NW-1:0];
            ht_wdata = '0;
            sweep_in      = flags.sweep_last ? '0 : sweep_ff + GAW'(1);
            cursor_in     = '0;
            text_in       = '0;
            nodes_used_in = NCW'(1);
            pat_used_in   = '0;
         end
         OP_PAT_WR: begin
            if (flags.g_zero && nodes_full) begin
               res_status_in = ST_NODE_FULL;
            end
            if (flags.g_zero && !nodes_full) begin
               g_we          = 1'b1;
               nodes_used_in = nodes_used_ff + NCW'(1);
            end
            if (pat_ok) begin
               cursor_in = nxt;
            end
            if (req_ff.last) begin
               cursor_in = '0;
               if (pat_ok) begin
                  if (pat_full) begin
                     res_status_in = ST_PATTERN_FULL;
                  end else begin
                     pe_we       = 1'b1;
                     tg_we       = 1'b1;
                     tg_waddr    = nxt;
                     tg_wdata    = 1'b1;
                     res_id_in   = 10'(pat_used_ff);
                     pat_used_in = pat_used_ff + PCW'(1);
                  end
               end
            end
         end
         OP_TXT_RD: begin
            fl_raddr = u_ff;
         end
         OP_TXT_CK: begin
            if (!flags.u_zero && flags.g_zero) begin
               u_in = fl_rd;
            end else begin
               u_in        = g_rd;
               text_in     = g_rd;
               f_in        = g_rd;
               res_node_in = 12'(g_rd);
            end
         end
         OP_SUF_CK: begin
            // tagged node: count it and step to its suffix
            if (tg_rd) begin
               ht_we = 1'b1;
               f_in  = fl_rd;
            end
         end
         OP_RD_HIT: begin
            ht_raddr = pe_rd;
         end
         OP_RD_OUT: begin
            res_hits_in = hits_sat;
         end
         OP_BR_CK: begin
            if (!flags.g_zero) begin
               fl_we    = 1'b1;
               fl_waddr = g_rd;
               fl_wdata = '0;
               qu_we    = 1'b1;
               qu_wdata = g_rd;
               tail_in  = tail_ff + NCW'(1);
            end
            sym_i_in = sym_i_next;
         end
         OP_BQ_POP: begin
            if (flags.q_empty) begin
               text_in = '0;
            end else begin
               head_in = head_ff + NCW'(1);
            end
         end
         OP_BQ_U: begin
            u_in     = qu_rd;
            fl_raddr = qu_rd;
         end
         OP_BQ_FU: begin
            fu_in = fl_rd;
         end
         OP_BC_CK: begin
            o_in = g_rd;
            f_in = fu_ff;
            if (flags.g_zero) begin
               sym_i_in = sym_i_next;
            end
         end
         OP_BF_CK: begin
            if (!flags.f_zero && flags.g_zero) begin
               f_in = fl_rd;
            end else begin
               fl_we    = 1'b1;
               f_in     = g_rd;
               tg_raddr = g_rd;
            end
         end
         OP_BT_F: begin
            tf_in    = tg_rd;
            tg_raddr = o_ff;
         end
         OP_BT_O: begin
            tg_we    = 1'b1;
            qu_we    = 1'b1;
            tail_in  = tail_ff + NCW'(1);
            sym_i_in = sym_i_next;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff     <= '0;
         text_ff       <= '0;
         nodes_used_ff <= NCW'(1);
         pat_used_ff   <= '0;
         sweep_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cursor_ff     <= cursor_in;
         text_ff       <= text_in;
         nodes_used_ff <= nodes_used_in;
         pat_used_ff   <= pat_used_in;
         sweep_ff      <= sweep_in;
         rsp_valid_ff  <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      u_ff          <= u_in;
      f_ff          <= f_in;
      o_ff          <= o_in;
      fu_ff         <= fu_in;
      tf_ff         <= tf_in;
      sym_i_ff      <= sym_i_in;
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      res_status_ff <= res_status_in;
      res_hits_ff   <= res_hits_in;
      res_id_ff     <= res_id_in;
      res_node_ff   <= res_node_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_item.status      = res_status_ff;
   assign rsp_item.hit_count   = res_hits_ff;
   assign rsp_item.assigned_id = res_id_ff;
   assign rsp_item.match_node  = res_node_ff;

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for multi_pattern_occurrence_counter
// depends on mpoc_pkg and the rtl below rtl/core; carries its own trie predictor
// runs a directed table, then random pattern/build/text/read sequences with clears and unused modes
module testbench;
   import mpoc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODE_CAP  = 4096;
   localparam int PAT_CAP   = 1024;
   localparam int LETTERS   = 26;
   localparam int IDLE_LIMIT = 500000;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } step_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   multi_pattern_occurrence_counter uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // predictor state
   bit [11:0] trie_next [NODE_CAP*LETTERS];
   bit [11:0] fail_to [NODE_CAP];
   bit        tag_bit [NODE_CAP];
   bit [31:0] node_hits [NODE_CAP];
   bit [11:0] end_node [PAT_CAP];
   int        nodes_used;
   int        pats_used;
   int        cursor;
   int        text_node;

   rsp_type   expected_rsp [$];
   step_type  typed_rows [$];
   int        mismatches;
   int        idle_cycles;
   int        burst_left;

   function automatic void clear_trie();
      foreach (trie_next[i]) trie_next[i] = '0;
      foreach (fail_to[i]) begin
         fail_to[i] = '0;
         tag_bit[i] = 1'b0;
         node_hits[i] = '0;
      end
      nodes_used = 1;
      pats_used = 0;
      cursor = 0;
      text_node = 0;
   endfunction

   function automatic void build_fail_links();
      int bfs [$];
      int u, o, f, guard, queued;
      queued = 0;
      for (int s = 0; s < LETTERS; s++) begin
         o = trie_next[s];
         if (o != 0 && queued < NODE_CAP) begin
            fail_to[o] = '0;
            bfs = {bfs, o};
            queued++;
         end
      end
      while (bfs.size() > 0) begin
         u = bfs.pop_front();
         for (int s = 0; s < LETTERS; s++) begin
            o = trie_next[u*LETTERS+s];
            if (o != 0) begin
               f = fail_to[u];
               guard = 0;
               while (f != 0 && trie_next[f*LETTERS+s] == 0 && guard < NODE_CAP) begin
                  f = fail_to[f];
                  guard++;
               end
               f = trie_next[f*LETTERS+s];
               fail_to[o] = 12'(f);
               tag_bit[o] = tag_bit[o] | tag_bit[f];
               if (queued < NODE_CAP) begin
                  bfs = {bfs, o};
                  queued++;
               end
            end
         end
      end
      text_node = 0;
   endfunction

   function automatic rsp_type predict_count(req_type r);
      rsp_type o;
      int nxt, u, guard;
      bit ok;
      o = '0;
      case (r.mode)
         MODE_PATTERN: begin
            if (r.symbol >= LETTERS) begin
               o.status = ST_BAD_INDEX;
            end else begin
               nxt = trie_next[cursor*LETTERS+r.symbol];
               ok = 1'b1;
               if (nxt == 0) begin
                  if (nodes_used >= NODE_CAP) begin
                     o.status = ST_NODE_FULL;
                     ok = 1'b0;
                  end else begin
                     nxt = nodes_used;
                     nodes_used++;
                     trie_next[cursor*LETTERS+r.symbol] = 12'(nxt);
                  end
               end
               if (ok) cursor = nxt;
               if (r.last) begin
                  if (ok) begin
                     if (pats_used >= PAT_CAP) begin
                        o.status = ST_PATTERN_FULL;
                     end else begin
                        end_node[pats_used] = 12'(nxt);
                        tag_bit[nxt] = 1'b1;
                        o.assigned_id = 10'(pats_used);
                        pats_used++;
                     end
                  end
                  cursor = 0;
               end
            end
         end
         MODE_BUILD: build_fail_links();
         MODE_TEXT: begin
            if (r.symbol >= LETTERS) begin
               o.status = ST_BAD_INDEX;
            end else begin
               u = text_node;
               guard = 0;
               while (u != 0 && trie_next[u*LETTERS+r.symbol] == 0 && guard < NODE_CAP) begin
                  u = fail_to[u];
                  guard++;
               end
               u = trie_next[u*LETTERS+r.symbol];
               text_node = u;
               guard = 0;
               for (int j = u; tag_bit[j] && guard < NODE_CAP; j = fail_to[j]) begin
                  if (node_hits[j] != 32'hFFFF_FFFF) node_hits[j]++;
                  guard++;
               end
               o.match_node = 12'(u);
            end
         end
         MODE_READ: begin
            o.assigned_id = r.pattern_index;
            if (r.pattern_index >= pats_used) o.status = ST_BAD_INDEX;
            else o.hit_count = node_hits[end_node[r.pattern_index]];
         end
         MODE_CLEAR: clear_trie();
         default: ;
      endcase
      return o;
   endfunction

   // accept and check at the rising edge
   always @(posedge clock) begin
      rsp_type w;
      step_type row;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result %p", rsp_item);
            end else begin
               w = expected_rsp.pop_front();
               if (rsp_item.status !== w.status || rsp_item.hit_count !== w.hit_count ||
                   rsp_item.assigned_id !== w.assigned_id ||
                   rsp_item.match_node !== w.match_node) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch at %0t: expected %p, got %p", $realtime, w, rsp_item);
               end
            end
         end
         if (start && !busy) begin
            idle_cycles = 0;
            row = typed_rows.pop_front();
            w = predict_count(req_item);
            expected_rsp = {expected_rsp, (row.typed ? row.want : w)};
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("testbench failed");
               $finish;
            end
         end
      end
   end

   // drive one item at the falling edge and hold it until taken
   task automatic send_item(req_type r, bit typed = 1'b0, rsp_type want = '0);
      step_type row;
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      row.req = r;
      row.typed = typed;
      row.want = want;
      typed_rows = {typed_rows, row};
      req_item <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   function automatic req_type make_item(logic [2:0] m, logic [4:0] s, logic l);
      req_type r;
      r.mode = m;
      r.symbol = s;
      r.last = l;
      r.pattern_index = 10'($urandom_range(0, 1023));
      return r;
   endfunction

   task automatic wait_idle();
      start <= 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
   endtask

   // classic he/she/his/hers example with error and unused-mode items
   step_type dir_tbl [27] = '{
      '{'{MODE_READ, 5'd0, 1'b0, 10'd0}, 1'b1, '{ST_BAD_INDEX, 32'd0, 10'd0, 12'd0}},
      '{'{3'd5, 5'd31, 1'b1, 10'd1023}, 1'b1, '{ST_OK, 32'd0, 10'd0, 12'd0}},
      '{'{3'd6, 5'd0, 1'b0, 10'd0}, 1'b1, '{ST_OK, 32'd0, 10'd0, 12'd0}},
      '{'{3'd7, 5'd25, 1'b1, 10'd512}, 1'b1, '{ST_OK, 32'd0, 10'd0, 12'd0}},
      '{'{MODE_PATTERN, 5'd26, 1'b1, 10'd0}, 1'b1, '{ST_BAD_INDEX, 32'd0, 10'd0, 12'd0}},
      '{'{MODE_TEXT, 5'd31, 1'b0, 10'd0}, 1'b1, '{ST_BAD_INDEX, 32'd0, 10'd0, 12'd0}},
      '{'{MODE_PATTERN, 5'd7, 1'b0, 10'd0}, 1'b1, '{ST_OK, 32'd0, 10'd0, 12'd0}},
      '{'{MODE_PATTERN, 5'd4, 1'b1, 10'd0}, 1'b1, '{ST_OK, 32'd0, 10'd0, 12'd0}},
      '{'{MODE_PATTERN, 5'd18, 1'b0, 10'd0}, 1'b1, '{ST_OK, 32'd0, 10'd0, 12'd0}},
      '{'{MODE_PATTERN, 5'd7, 1'b0, 10'd0}, 1'b1, '{ST_OK, 32'd0, 10'd0, 12'd0}},
      '{'{MODE_PATTERN, 5'd4, 1'b1, 10'd0}, 1'b1, '{ST_OK, 32'd0, 10'd1, 12'd0}},
      '{'{MODE_PATTERN, 5'd7, 1'b0, 10'd0}, 1'b1, '{ST_OK, 32'd0, 10'd0, 12'd0}},
      '{'{MODE_PATTERN, 5'd8, 1'b0, 10'd0}, 1'b1, '{ST_OK, 32'd0, 10'd0, 12'd0}},
      '{'{MODE_PATTERN, 5'd18, 1'b1, 10'd0}, 1'b1, '{ST_OK, 32'd0, 10'd2, 12'd0}},
      '{'{MODE_PATTERN, 5'd7, 1'b0, 10'd0}, 1'b0, '0},
      '{'{MODE_PATTERN, 5'd4, 1'b0, 10'd0}, 1'b0, '0},
      '{'{MODE_PATTERN, 5'd17, 1'b0, 10'd0}, 1'b0, '0},
      '{'{MODE_PATTERN, 5'd18, 1'b1, 10'd0}, 1'b1, '{ST_OK, 32'd0, 10'd3, 12'd0}},
      '{'{MODE_BUILD, 5'd0, 1'b0, 10'd0}, 1'b1, '{ST_OK, 32'd0, 10'd0, 12'd0}},
      '{'{MODE_TEXT, 5'd20, 1'b0, 10'd0}, 1'b0, '0},
      '{'{MODE_TEXT, 5'd18, 1'b0, 10'd0}, 1'b0, '0},
      '{'{MODE_TEXT, 5'd7, 1'b0, 10'd0}, 1'b0, '0},
      '{'{MODE_TEXT, 5'd4, 1'b0, 10'd0}, 1'b0, '0},
      '{'{MODE_TEXT, 5'd17, 1'b0, 10'd0}, 1'b0, '0},
      '{'{MODE_TEXT, 5'd18, 1'b0, 10'd0}, 1'b0, '0},
      '{'{MODE_READ, 5'd0, 1'b0, 10'd3}, 1'b0, '0},
      '{'{MODE_READ, 5'd0, 1'b0, 10'd1023}, 1'b1, '{ST_BAD_INDEX, 32'd0, 10'd1023, 12'd0}}
   };

   function automatic logic [4:0] pick_letter(int odd_pct);
      if ($urandom_range(0, 99) < odd_pct) return 5'($urandom_range(0, 31));
      return 5'($urandom_range(0, 3));
   endfunction

   initial begin
      int issued, len, hi;
      mismatches = 0;
      idle_cycles = 0;
      burst_left = 0;
      clear_trie();
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_tbl[i]) send_item(dir_tbl[i].req, dir_tbl[i].typed, dir_tbl[i].want);
      wait_idle();

      issued = 0;
      while (issued < 570) begin
         if ($urandom_range(0, 99) < 3) begin
            send_item(make_item(MODE_CLEAR, 5'd0, 1'b0));
            issued++;
         end
         for (int p = $urandom_range(1, 4); p > 0; p--) begin
            len = $urandom_range(1, 5);
            for (int k = 1; k <= len; k++) begin
               send_item(make_item(MODE_PATTERN, pick_letter(4), k == len));
               issued++;
            end
         end
         if ($urandom_range(0, 99) < 80) begin
            send_item(make_item(MODE_BUILD, 5'($urandom_range(0, 31)),
                                1'($urandom_range(0, 1))));
            issued++;
         end
         for (int t = $urandom_range(10, 40); t > 0; t--) begin
            send_item(make_item(MODE_TEXT, pick_letter(3), 1'($urandom_range(0, 1))));
            issued++;
         end
         for (int q = $urandom_range(1, 5); q > 0; q--) begin
            hi = pats_used + 2;
            if ($urandom_range(0, 9) == 0) hi = 1023;
            send_item('{MODE_READ, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                        10'($urandom_range(0, hi))});
            issued++;
         end
         if ($urandom_range(0, 9) == 0) begin
            send_item(make_item(3'($urandom_range(5, 7)), 5'($urandom_range(0, 31)), 1'b1));
            issued++;
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
